>>> rtl/i2cmbe_pkg.sv
package i2cmbe_pkg;

  // Command codes, also the value of the running-operation register
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam int unsigned PHASE_BITS = 5;
  localparam int unsigned CFG_BITS   = 16;
  localparam logic [CFG_BITS-1:0] PHASE_TICKS_RST = 16'd10;

  // Sequence lengths in bus phases
  localparam logic [PHASE_BITS-1:0] LEN_START = 5'd3;
  localparam logic [PHASE_BITS-1:0] LEN_STOP  = 5'd4;
  localparam logic [PHASE_BITS-1:0] LEN_WRITE = 5'd27;
  localparam logic [PHASE_BITS-1:0] LEN_READ  = 5'd19;

  // Write phase layout
  localparam logic [PHASE_BITS-1:0] WR_ACK_REL  = 5'd24;
  localparam logic [PHASE_BITS-1:0] WR_ACK_HIGH = 5'd25;
  // Read phase layout
  localparam logic [PHASE_BITS-1:0] RD_ACK_DRV  = 5'd16;
  localparam logic [PHASE_BITS-1:0] RD_ACK_HIGH = 5'd17;

  // Slot within a three-phase data bit
  typedef enum logic [1:0] {
    SLOT_DATA = 2'd0,
    SLOT_HIGH = 2'd1,
    SLOT_LOW  = 2'd2
  } slot_t;

  typedef struct packed {
    logic       tick;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  // Engine status seen by the top level
  typedef struct packed {
    op_t                   op;
    logic [PHASE_BITS-1:0] phase_index;
  } status_t;

  function automatic logic [PHASE_BITS-1:0] seq_length(input op_t op);
    logic [PHASE_BITS-1:0] len;
    case (op)
      OP_START: len = LEN_START;
      OP_STOP:  len = LEN_STOP;
      OP_WRITE: len = LEN_WRITE;
      OP_READ:  len = LEN_READ;
      default:  len = '0;
    endcase
    return len;
  endfunction

  // Phase within a write data bit (only meaningful below WR_ACK_REL)
  function automatic slot_t bit_slot(input logic [PHASE_BITS-1:0] idx);
    slot_t s;
    case (idx)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21: s = SLOT_DATA;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: s = SLOT_HIGH;
      default: s = SLOT_LOW;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/i2cmbe_core.sv
module i2cmbe_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  i2cmbe_pkg::in_t                      item,
  input  logic [i2cmbe_pkg::CFG_BITS-1:0]      phase_ticks,
  output i2cmbe_pkg::out_t                     res,
  output i2cmbe_pkg::status_t                  status
);

  localparam int unsigned CW = ((TIMER_BITS > i2cmbe_pkg::CFG_BITS) ?
                                TIMER_BITS : i2cmbe_pkg::CFG_BITS) + 1;
  localparam logic [CW-1:0] CAP = CW'(1) << TIMER_BITS;

  logic [TIMER_BITS-1:0]              phase_timer, phase_timer_next;
  logic [i2cmbe_pkg::PHASE_BITS-1:0]  phase_index, phase_index_next;
  i2cmbe_pkg::op_t                    current_op, current_op_next;
  logic [7:0]                         shift_reg, shift_reg_next;
  logic                               ack_choice, ack_choice_next;
  logic                               ack_flag, ack_flag_next;
  i2cmbe_pkg::pins_t                  pins, pins_next;
  logic [7:0]                         rx_hold, rx_hold_next;

  logic [CW-1:0]                      timer_inc;
  logic [CW-1:0]                      period;
  logic [i2cmbe_pkg::PHASE_BITS-1:0]  idx_inc;
  logic [i2cmbe_pkg::PHASE_BITS-1:0]  enter_idx;
  logic                               enter;
  logic                               done;
  logic                               req_ok;

  assign timer_inc = CW'(phase_timer) + CW'(1);
  assign idx_inc   = phase_index + 5'd1;
  assign req_ok    = (item.req_type >= 3'(i2cmbe_pkg::OP_START)) &&
                     (item.req_type <= 3'(i2cmbe_pkg::OP_READ));

  always_comb begin
    if (phase_ticks == '0) begin
      period = CW'(1);
    end else if (CW'(phase_ticks) > CAP) begin
      period = CAP;
    end else begin
      period = CW'(phase_ticks);
    end
  end

  always_comb begin
    phase_timer_next = phase_timer;
    phase_index_next = phase_index;
    current_op_next  = current_op;
    shift_reg_next   = shift_reg;
    ack_choice_next  = ack_choice;
    ack_flag_next    = ack_flag;
    pins_next        = pins;
    rx_hold_next     = rx_hold;
    enter            = 1'b0;
    enter_idx        = '0;
    done             = 1'b0;

    if (current_op == i2cmbe_pkg::OP_IDLE) begin
      if (req_ok) begin
        current_op_next  = i2cmbe_pkg::op_t'(item.req_type);
        phase_timer_next = '0;
        phase_index_next = '0;
        ack_choice_next  = item.send_ack;
        shift_reg_next   = (item.req_type == 3'(i2cmbe_pkg::OP_WRITE)) ?
                           item.tx_byte : 8'h00;
        enter            = 1'b1;
      end
    end else if (item.tick) begin
      if (timer_inc >= period) begin
        phase_timer_next = '0;
        if (idx_inc >= i2cmbe_pkg::seq_length(current_op)) begin
          if (current_op == i2cmbe_pkg::OP_WRITE) begin
            pins_next.drv = 1'b1;
          end else if (current_op == i2cmbe_pkg::OP_READ) begin
            rx_hold_next = shift_reg;
          end
          current_op_next  = i2cmbe_pkg::OP_IDLE;
          phase_index_next = '0;
          done             = 1'b1;
        end else begin
          phase_index_next = idx_inc;
          enter            = 1'b1;
          enter_idx        = idx_inc;
        end
      end else begin
        phase_timer_next = timer_inc[TIMER_BITS-1:0];
      end
    end

    // Pin changes at the start of a phase
    if (enter) begin
      case (current_op_next)
        i2cmbe_pkg::OP_START: begin
          if (enter_idx == 5'd0) begin
            pins_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
          end else if (enter_idx == 5'd1) begin
            pins_next.sda = 1'b0;
          end else begin
            pins_next.scl = 1'b0;
          end
        end
        i2cmbe_pkg::OP_STOP: begin
          if (enter_idx == 5'd0) begin
            pins_next.scl = 1'b0;
          end else if (enter_idx == 5'd1) begin
            pins_next.sda = 1'b0;
            pins_next.drv = 1'b1;
          end else if (enter_idx == 5'd2) begin
            pins_next.scl = 1'b1;
          end else begin
            pins_next.sda = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WRITE: begin
          if (enter_idx < i2cmbe_pkg::WR_ACK_REL) begin
            case (i2cmbe_pkg::bit_slot(enter_idx))
              i2cmbe_pkg::SLOT_DATA: begin
                pins_next.sda  = shift_reg_next[7];
                pins_next.drv  = 1'b1;
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
              end
              i2cmbe_pkg::SLOT_HIGH: pins_next.scl = 1'b1;
              default:               pins_next.scl = 1'b0;
            endcase
          end else if (enter_idx == i2cmbe_pkg::WR_ACK_REL) begin
            pins_next.drv = 1'b0;
          end else if (enter_idx == i2cmbe_pkg::WR_ACK_HIGH) begin
            pins_next.scl = 1'b1;
          end else begin
            // SCL falls after the acknowledge clock: sample the slave's answer
            ack_flag_next = item.sda_in;
            pins_next.scl = 1'b0;
          end
        end
        i2cmbe_pkg::OP_READ: begin
          if (enter_idx == 5'd0) begin
            pins_next.drv = 1'b0;
          end else if (enter_idx < i2cmbe_pkg::RD_ACK_DRV) begin
            if (enter_idx[0]) begin
              pins_next.scl  = 1'b1;
              shift_reg_next = {shift_reg_next[6:0], item.sda_in};
            end else begin
              pins_next.scl = 1'b0;
            end
          end else if (enter_idx == i2cmbe_pkg::RD_ACK_DRV) begin
            pins_next.scl = 1'b0;
            pins_next.drv = 1'b1;
            pins_next.sda = ~ack_choice_next;
          end else if (enter_idx == i2cmbe_pkg::RD_ACK_HIGH) begin
            pins_next.scl = 1'b1;
          end else begin
            pins_next.scl = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_timer <= '0;
      phase_index <= '0;
      current_op  <= i2cmbe_pkg::OP_IDLE;
      shift_reg   <= '0;
      ack_choice  <= 1'b0;
      ack_flag    <= 1'b0;
      pins        <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      rx_hold     <= '0;
    end else if (step) begin
      phase_timer <= phase_timer_next;
      phase_index <= phase_index_next;
      current_op  <= current_op_next;
      shift_reg   <= shift_reg_next;
      ack_choice  <= ack_choice_next;
      ack_flag    <= ack_flag_next;
      pins        <= pins_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // Result reflects the state after this item
  assign res.scl_level = pins_next.scl;
  assign res.sda_level = pins_next.sda;
  assign res.sda_drive = pins_next.drv;
  assign res.busy_res  = (current_op_next != i2cmbe_pkg::OP_IDLE);
  assign res.done_res  = done;
  assign res.rx_byte   = rx_hold_next;
  assign res.ack_seen  = ack_flag_next;

  assign status.op          = current_op;
  assign status.phase_index = phase_index;

endmodule

>>> rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine. While idle, one command (start, stop, write byte,
// read byte) is taken from an input transaction; every later transaction with
// tick set counts one timebase tick, and after phase_ticks ticks (zero counts
// as one, saturating at 2^TIMER_BITS) the next SCL/SDA phase is applied.
// Start is 3 phases, stop 4, write 27 (8 bits MSB first, 3 phases each, then
// a released acknowledge slot whose level is reported in ack_seen), read 19
// (release, 8 data bits sampling SDA on the rising SCL, then one driven
// ACK/NACK bit chosen by send_ack). Each input transaction yields exactly one
// output transaction carrying the pin levels and status after it. Throughput
// is one transaction per clock while not stalled; each result is held in the
// output register. The input is stalled only while that register holds a
// result the downstream side is stalling. phase_ticks is written over the cfg
// channel and must only change while the engine is idle.
module i2c_master_bit_engine_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // command / tick stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  i2cmbe_pkg::in_t                  in_data,
  // per-item result stream
  output logic                             out_valid,
  input  logic                             out_stall,
  output i2cmbe_pkg::out_t                 out_data,
  // phase_ticks register write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cmbe_pkg::CFG_BITS-1:0]  cfg_data
);

  logic [i2cmbe_pkg::CFG_BITS-1:0] phase_ticks;
  logic                            in_accept;
  logic                            out_take;
  i2cmbe_pkg::out_t                res;
  i2cmbe_pkg::status_t             status;

  // Result slot frees in the same cycle it is taken
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cmbe_pkg::PHASE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  i2cmbe_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_accept),
    .item        (in_data),
    .phase_ticks (phase_ticks),
    .res         (res),
    .status      (status)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= res;
    end
  end

  // Every accepted transaction produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // Completion always returns the engine to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res.done_res) |=> (status.op == i2cmbe_pkg::OP_IDLE))
    else $error("engine still busy after done");

  // Phase index stays inside the running sequence, and parks at zero in idle
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (status.op != i2cmbe_pkg::OP_IDLE) |->
      (status.phase_index < i2cmbe_pkg::seq_length(status.op)))
    else $error("phase index beyond sequence length");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (status.op == i2cmbe_pkg::OP_IDLE) |-> (status.phase_index == '0))
    else $error("phase index nonzero while idle");

endmodule

>>> test/i2c_master_bit_engine_top_tb.sv
module i2c_master_bit_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Bus phase tracker: mirrors the engine's sequencer, holds the pin/status
  // words it predicts, and compares each output transaction against the oldest.
  // ---------------------------------------------------------------------------
  class bus_phase_checker;
    logic [15:0]          ticks_cfg;
    int unsigned          tick_count;
    logic [4:0]           phase_num;
    i2cmbe_pkg::op_t      op;
    logic [7:0]           shreg;
    logic [7:0]           rx_keep;
    logic                 ack_sel;
    logic                 ack_level;
    logic                 scl, sda, drv;
    i2cmbe_pkg::out_t     pin_state_q[$];
    int unsigned          mismatches;
    int unsigned          compared;
    int unsigned          cmd_seen[8];

    function new();
      ticks_cfg  = i2cmbe_pkg::PHASE_TICKS_RST;
      tick_count = 0;
      phase_num  = '0;
      op         = i2cmbe_pkg::OP_IDLE;
      shreg      = '0;
      rx_keep    = '0;
      ack_sel    = 1'b0;
      ack_level  = 1'b0;
      scl        = 1'b1;
      sda        = 1'b1;
      drv        = 1'b1;
      mismatches = 0;
      compared   = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function bit busy();
      return op != i2cmbe_pkg::OP_IDLE;
    endfunction

    function int unsigned pending();
      return pin_state_q.size();
    endfunction

    function void set_phase_ticks(logic [15:0] v);
      ticks_cfg = v;
    endfunction

    function logic [4:0] phases_of(i2cmbe_pkg::op_t o);
      case (o)
        i2cmbe_pkg::OP_START: return 5'd3;
        i2cmbe_pkg::OP_STOP:  return 5'd4;
        i2cmbe_pkg::OP_WRITE: return 5'd27;
        i2cmbe_pkg::OP_READ:  return 5'd19;
        default:              return 5'd0;
      endcase
    endfunction

    // pin changes applied when phase idx begins
    function void begin_phase(logic [4:0] idx, logic line);
      case (op)
        i2cmbe_pkg::OP_START: begin
          if (idx == 0) begin
            scl = 1'b1; sda = 1'b1; drv = 1'b1;
          end else if (idx == 1) begin
            sda = 1'b0;
          end else begin
            scl = 1'b0;
          end
        end
        i2cmbe_pkg::OP_STOP: begin
          if (idx == 0) scl = 1'b0;
          else if (idx == 1) begin
            sda = 1'b0; drv = 1'b1;
          end else if (idx == 2) scl = 1'b1;
          else sda = 1'b1;
        end
        i2cmbe_pkg::OP_WRITE: begin
          if (idx < 24) begin
            case (idx % 3)
              0: begin
                sda   = shreg[7];
                drv   = 1'b1;
                shreg = {shreg[6:0], 1'b0};
              end
              1: scl = 1'b1;
              default: scl = 1'b0;
            endcase
          end else if (idx == 24) begin
            drv = 1'b0;
          end else if (idx == 25) begin
            scl = 1'b1;
          end else begin
            ack_level = line;
            scl       = 1'b0;
          end
        end
        i2cmbe_pkg::OP_READ: begin
          if (idx == 0) begin
            drv = 1'b0;
          end else if (idx < 16) begin
            if (idx[0]) begin
              scl   = 1'b1;
              shreg = {shreg[6:0], line};
            end else begin
              scl = 1'b0;
            end
          end else if (idx == 16) begin
            scl = 1'b0;
            drv = 1'b1;
            sda = !ack_sel;
          end else if (idx == 17) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted input transaction -> one predicted output word
    function void take_item(i2cmbe_pkg::in_t d);
      i2cmbe_pkg::out_t e;
      logic             done;
      int unsigned      period;
      done = 1'b0;
      if (op == i2cmbe_pkg::OP_IDLE) begin
        if (d.req_type >= i2cmbe_pkg::OP_START && d.req_type <= i2cmbe_pkg::OP_READ) begin
          op         = i2cmbe_pkg::op_t'(d.req_type);
          cmd_seen[d.req_type]++;
          tick_count = 0;
          phase_num  = '0;
          ack_sel    = d.send_ack;
          shreg      = (op == i2cmbe_pkg::OP_WRITE) ? d.tx_byte : 8'h00;
          begin_phase(5'd0, d.sda_in);
        end
      end else if (d.tick) begin
        period = (ticks_cfg == 0) ? 1 : ticks_cfg;
        if (tick_count + 1 >= period) begin
          tick_count = 0;
          phase_num  = phase_num + 5'd1;
          if (phase_num >= phases_of(op)) begin
            if (op == i2cmbe_pkg::OP_WRITE) drv = 1'b1;
            else if (op == i2cmbe_pkg::OP_READ) rx_keep = shreg;
            op        = i2cmbe_pkg::OP_IDLE;
            phase_num = '0;
            done      = 1'b1;
          end else begin
            begin_phase(phase_num, d.sda_in);
          end
        end else begin
          tick_count = (tick_count + 1) & 32'hFFFF;
        end
      end
      e.scl_level = scl;
      e.sda_level = sda;
      e.sda_drive = drv;
      e.busy_res  = (op != i2cmbe_pkg::OP_IDLE);
      e.done_res  = done;
      e.rx_byte   = rx_keep;
      e.ack_seen  = ack_level;
      pin_state_q.push_back(e);
    endfunction

    function void compare_result(i2cmbe_pkg::out_t got);
      i2cmbe_pkg::out_t e;
      if (pin_state_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] output transaction with nothing predicted: %p", $realtime, got);
        return;
      end
      e = pin_state_q.pop_front();
      compared++;
      if (got.scl_level !== e.scl_level || got.sda_level !== e.sda_level ||
          got.sda_drive !== e.sda_drive || got.busy_res !== e.busy_res ||
          got.done_res !== e.done_res || got.rx_byte !== e.rx_byte ||
          got.ack_seen !== e.ack_seen) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch on result %0d", $realtime, compared);
          $display("  exp scl=%b sda=%b drv=%b busy=%b done=%b rx=%h ack=%b",
                   e.scl_level, e.sda_level, e.sda_drive, e.busy_res, e.done_res,
                   e.rx_byte, e.ack_seen);
          $display("  got scl=%b sda=%b drv=%b busy=%b done=%b rx=%h ack=%b",
                   got.scl_level, got.sda_level, got.sda_drive, got.busy_res,
                   got.done_res, got.rx_byte, got.ack_seen);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  i2cmbe_pkg::in_t                 in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  i2cmbe_pkg::out_t                out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [i2cmbe_pkg::CFG_BITS-1:0] cfg_data = '0;

  i2c_master_bit_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  bus_phase_checker chk = new();

  bit          calm = 1'b0;   // set during the stretch with no idling on either side
  int unsigned settings_used = 0;

  // ~32% idle/stall per cycle unless in the calm stretch
  function automatic bit gap_now();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // SDA level to present on the next tick: during a read feed the data bit that
  // the upcoming SCL rise samples, elsewhere the chosen acknowledge level.
  function automatic logic line_level(logic [7:0] bits, logic ack_lvl);
    if (chk.op == i2cmbe_pkg::OP_READ && chk.phase_num < 16)
      return bits[7 - (chk.phase_num >> 1)];
    return ack_lvl;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel. Handshake sampled at the falling edge (everything settles
  // after the rising edge), applied at the next rising edge. Valid is kept high
  // across back-to-back transactions so it never toggles twice in one step.
  // ---------------------------------------------------------------------------
  task automatic push_item(i2cmbe_pkg::in_t d);
    bit took;
    while (gap_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    chk.take_item(d);
  endtask

  // Issue one command, then tick it through to completion. The noise request
  // rides along on every tick transaction and must be ignored while busy;
  // every fifth tick transaction has tick low.
  task automatic issue_command(i2cmbe_pkg::op_t o, logic [7:0] tx, logic sack,
                               logic [7:0] rd_bits, logic ack_lvl, logic [2:0] noise_req);
    i2cmbe_pkg::in_t d;
    int unsigned     n;
    d.tick     = 1'b1;
    d.req_type = o;
    d.tx_byte  = tx;
    d.send_ack = sack;
    d.sda_in   = ack_lvl;
    push_item(d);
    n = 0;
    while (chk.busy()) begin
      d.tick     = (n % 5) != 4;
      d.req_type = noise_req;
      d.tx_byte  = ~tx;
      d.send_ack = ~sack;
      d.sda_in   = line_level(rd_bits, ack_lvl);
      push_item(d);
      n++;
    end
  endtask

  // Finish whatever command is running with random noise on the other fields.
  task automatic run_to_idle();
    i2cmbe_pkg::in_t d;
    while (chk.busy()) begin
      d.tick     = 1'b1;
      d.req_type = 3'($urandom_range(7));
      d.tx_byte  = 8'($urandom_range(255));
      d.send_ack = 1'($urandom_range(1));
      d.sda_in   = 1'($urandom_range(1));
      push_item(d);
    end
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_phase_ticks(logic [15:0] v);
    bit took;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    chk.set_phase_ticks(v);
    settings_used++;
  endtask

  // Random traffic: when idle mostly a fresh command right away (often on the
  // transaction after done), some no-ops and unknown codes; while busy mostly
  // ticks with stray requests mixed in.
  task automatic random_items(int unsigned count, int unsigned calm_count);
    i2cmbe_pkg::in_t d;
    int unsigned     r;
    for (int unsigned i = 0; i < count; i++) begin
      calm       = (i < calm_count);
      d.tick     = $urandom_range(99) < 70;
      d.tx_byte  = 8'($urandom_range(255));
      d.send_ack = 1'($urandom_range(1));
      d.sda_in   = 1'($urandom_range(1));
      if (!chk.busy()) begin
        r = $urandom_range(99);
        if (r < 75)
          d.req_type = 3'($urandom_range(i2cmbe_pkg::OP_READ, i2cmbe_pkg::OP_START));
        else if (r < 85) d.req_type = i2cmbe_pkg::OP_IDLE;
        else d.req_type = 3'($urandom_range(7, 5));
      end else begin
        d.req_type = ($urandom_range(99) < 85) ? i2cmbe_pkg::OP_IDLE :
                     3'($urandom_range(7));
      end
      push_item(d);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output channel: random stall, check every accepted result transaction.
  // ---------------------------------------------------------------------------
  initial begin
    i2cmbe_pkg::out_t seen;
    bit               took;
    forever begin
      @(negedge clk);
      took = (out_valid === 1'b1) && !out_stall;
      seen = out_data;
      @(posedge clk);
      if (took && !rst) chk.compare_result(seen);
      out_stall <= gap_now();
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    i2cmbe_pkg::in_t d;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset value of phase_ticks (10): an idle no-op, then a start
    d = '0;
    push_item(d);
    issue_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, i2cmbe_pkg::OP_IDLE);
    settle();

    // directed part at one tick per phase
    load_phase_ticks(16'd1);
    d = '0;
    d.tick = 1'b1;
    d.req_type = 3'd5; push_item(d);   // unknown codes while idle are no-ops
    d.req_type = 3'd6; push_item(d);
    d.req_type = 3'd7; push_item(d);
    d.tick = 1'b0; d.req_type = i2cmbe_pkg::OP_IDLE; push_item(d);
    issue_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b1, i2cmbe_pkg::OP_STOP);
    // all-ones byte, nack in the ack slot, read request while busy
    issue_command(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1, i2cmbe_pkg::OP_READ);
    // all-zeros byte, ack seen
    issue_command(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b0, 8'hFF, 1'b0, i2cmbe_pkg::OP_WRITE);
    issue_command(i2cmbe_pkg::OP_WRITE, 8'h80, 1'b0, 8'h00, 1'b0, 3'd7);
    issue_command(i2cmbe_pkg::OP_WRITE, 8'h01, 1'b1, 8'h00, 1'b1, i2cmbe_pkg::OP_START);
    // reads: ack driven, then not-acknowledge, then ack driven again
    issue_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, 8'hA5, 1'b0, i2cmbe_pkg::OP_WRITE);
    issue_command(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, 8'h5A, 1'b1, i2cmbe_pkg::OP_START);
    issue_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, 8'hFF, 1'b0, i2cmbe_pkg::OP_IDLE);
    issue_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, i2cmbe_pkg::OP_WRITE);
    issue_command(i2cmbe_pkg::OP_STOP, 8'hFF, 1'b1, 8'h00, 1'b1, i2cmbe_pkg::OP_IDLE);

    // random phases over several periods, zero (acts as one) among them
    random_items(400, 0);
    run_to_idle();
    settle();
    load_phase_ticks(16'd0);
    random_items(300, 0);
    run_to_idle();
    settle();
    load_phase_ticks(16'd3);
    random_items(400, 0);
    run_to_idle();
    settle();
    load_phase_ticks(16'($urandom_range(6, 2)));
    random_items(450, 300);
    run_to_idle();
    settle();

    if (chk.pending() != 0) begin
      $display("%0d predicted results never came out", chk.pending());
      chk.mismatches += chk.pending();
    end
    $display("Covered %0d start, %0d stop, %0d write, %0d read commands",
             chk.cmd_seen[i2cmbe_pkg::OP_START], chk.cmd_seen[i2cmbe_pkg::OP_STOP],
             chk.cmd_seen[i2cmbe_pkg::OP_WRITE], chk.cmd_seen[i2cmbe_pkg::OP_READ]);
    $display("over %0d period settings; %0d result transactions compared, %0d mismatches",
             settings_used + 1, chk.compared, chk.mismatches);
    if (chk.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_core.sv
rtl/i2c_master_bit_engine_top.sv
test/i2c_master_bit_engine_top_tb.sv
